@@ rtl/vudc_pkg.sv @@
package vudc_pkg;

    // square root unit: result bits, one per stage
    localparam int SQ_N = 27;
    localparam int SQ_W = 2 * SQ_N;
    // divider: divisor width and quotient bits, one per stage
    localparam int DV_W = SQ_N;
    localparam int DV_Q = 18;

    localparam logic [31:0] ONE_Q24 = 32'h0100_0000;

    typedef struct packed {
        logic signed [15:0] cur_vel_x;
        logic signed [15:0] cur_vel_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic               has_pending;
        logic signed [15:0] pend_vel_x;
        logic signed [15:0] pend_vel_y;
        logic [15:0]        accel;
        logic [15:0]        loss_factor;
        logic [14:0]        max_speed;
        logic [15:0]        step_time;
    } t_vel_req;

    typedef struct packed {
        logic signed [15:0] new_vel_x;
        logic signed [15:0] new_vel_y;
        logic               was_clamped;
    } t_vel_rsp;

    typedef struct packed {
        logic [SQ_N+1:0] rem;
        logic [SQ_N-1:0] root;
        logic [SQ_W-1:0] src;
    } t_sq;

    typedef struct packed {
        logic [DV_W-1:0] rem;
        logic [DV_Q-1:0] tail;
        logic [DV_Q-1:0] quo;
    } t_dv;

    // velocity after acceleration or drag, before the speed cap
    typedef struct packed {
        logic signed [18:0] vx;
        logic signed [18:0] vy;
        logic [14:0]        ms;
    } t_mid;

    // one root bit: bring down two bits, try (root << 2) | 1
    function automatic t_sq sq_step(input t_sq s);
        t_sq             o;
        logic [SQ_N+1:0] r;
        logic [SQ_N+1:0] t;
        r = {s.rem[SQ_N-1:0], s.src[SQ_W-1 -: 2]};
        t = {s.root, 2'b01};
        o.src = {s.src[SQ_W-3:0], 2'b00};
        if (r >= t) begin
            o.rem  = r - t;
            o.root = {s.root[SQ_N-2:0], 1'b1};
        end else begin
            o.rem  = r;
            o.root = {s.root[SQ_N-2:0], 1'b0};
        end
        return o;
    endfunction

    // one quotient bit of a restoring divide
    function automatic t_dv dv_step(input t_dv s, input logic [DV_W-1:0] d);
        t_dv           o;
        logic [DV_W:0] r;
        logic [DV_W:0] dd;
        r  = {s.rem, s.tail[DV_Q-1]};
        dd = {1'b0, d};
        o.tail = {s.tail[DV_Q-2:0], 1'b0};
        if (r >= dd) begin
            o.rem = DV_W'(r - dd);
            o.quo = {s.quo[DV_Q-2:0], 1'b1};
        end else begin
            o.rem = r[DV_W-1:0];
            o.quo = {s.quo[DV_Q-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

@@ rtl/vudc_front.sv @@
module vudc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  vudc_pkg::t_vel_req i_req,
    output logic               o_valid,
    output vudc_pkg::t_mid     o_mid
);

    localparam int FS_LAST = vudc_pkg::SQ_N + vudc_pkg::DV_Q;

    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic               svx;
        logic               svy;
        logic [15:0]        mvx;
        logic [15:0]        mvy;
        logic               sx;
        logic               sy;
        logic [15:0]        mdx;
        logic [15:0]        mdy;
        logic               dir_nz;
        logic [31:0]        adt;
        logic [31:0]        lprod;
        logic [24:0]        drag;
        logic [14:0]        ms;
        vudc_pkg::t_sq      sq;
        vudc_pkg::t_dv      dvx;
        vudc_pkg::t_dv      dvy;
    } t_front;

    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic               sx;
        logic               sy;
        logic               svx;
        logic               svy;
        logic               dir_nz;
        logic [14:0]        ms;
        logic [17:0]        dvx;
        logic [17:0]        dvy;
        logic [16:0]        dgx;
        logic [16:0]        dgy;
    } t_fmul;

    t_front             r_fp [0:FS_LAST];
    t_front             n_fp [0:FS_LAST];
    logic [FS_LAST:0]   r_fv;
    t_fmul              r_mul;
    t_fmul              n_mul;
    logic               r_mv;
    vudc_pkg::t_mid     r_mid;
    vudc_pkg::t_mid     n_mid;
    logic               r_dv;

    always_comb begin
        logic signed [15:0] vsx;
        logic signed [15:0] vsy;
        logic [15:0]        ax;
        logic [15:0]        ay;
        logic [15:0]        bx;
        logic [15:0]        by;
        logic [31:0]        l2;
        vudc_pkg::t_dv      tx;
        vudc_pkg::t_dv      ty;
        vsx = i_req.has_pending ? i_req.pend_vel_x : i_req.cur_vel_x;
        vsy = i_req.has_pending ? i_req.pend_vel_y : i_req.cur_vel_y;
        ax  = vsx;
        ay  = vsy;
        bx  = i_req.dir_x;
        by  = i_req.dir_y;
        tx  = '0;
        ty  = '0;
        n_fp[0]        = '0;
        n_fp[0].vx     = vsx;
        n_fp[0].vy     = vsy;
        n_fp[0].svx    = ax[15];
        n_fp[0].svy    = ay[15];
        n_fp[0].mvx    = ax[15] ? 16'(~ax + 16'd1) : ax;
        n_fp[0].mvy    = ay[15] ? 16'(~ay + 16'd1) : ay;
        n_fp[0].sx     = bx[15];
        n_fp[0].sy     = by[15];
        n_fp[0].mdx    = bx[15] ? 16'(~bx + 16'd1) : bx;
        n_fp[0].mdy    = by[15] ? 16'(~by + 16'd1) : by;
        n_fp[0].dir_nz = (|bx) || (|by);
        n_fp[0].adt    = {16'b0, i_req.accel} * {16'b0, i_req.step_time};
        n_fp[0].lprod  = {16'b0, i_req.loss_factor} * {16'b0, i_req.step_time};
        n_fp[0].ms     = i_req.max_speed;
        l2 = ({16'b0, n_fp[0].mdx} * {16'b0, n_fp[0].mdx})
           + ({16'b0, n_fp[0].mdy} * {16'b0, n_fp[0].mdy});
        n_fp[0].sq.src = {6'b0, l2, 16'b0};

        for (int k = 1; k <= FS_LAST; k++) begin
            n_fp[k] = r_fp[k-1];
            if (k == 1) begin
                n_fp[k].drag = (r_fp[k-1].lprod >= vudc_pkg::ONE_Q24) ? 25'd0 :
                               25'(vudc_pkg::ONE_Q24 - r_fp[k-1].lprod);
            end
            if (k <= vudc_pkg::SQ_N) begin
                n_fp[k].sq = vudc_pkg::sq_step(r_fp[k-1].sq);
            end else begin
                if (k == vudc_pkg::SQ_N + 1) begin
                    // unit vector: (|d| << 24) / (len << 8), low numerator bits are zero
                    tx.rem  = vudc_pkg::DV_W'({r_fp[k-1].mdx, 6'b0});
                    tx.tail = '0;
                    tx.quo  = '0;
                    ty.rem  = vudc_pkg::DV_W'({r_fp[k-1].mdy, 6'b0});
                    ty.tail = '0;
                    ty.quo  = '0;
                end else begin
                    tx = r_fp[k-1].dvx;
                    ty = r_fp[k-1].dvy;
                end
                n_fp[k].dvx = vudc_pkg::dv_step(tx, r_fp[k-1].sq.root);
                n_fp[k].dvy = vudc_pkg::dv_step(ty, r_fp[k-1].sq.root);
            end
        end
    end

    always_comb begin
        logic [49:0] px;
        logic [49:0] py;
        logic [40:0] gx;
        logic [40:0] gy;
        px = {18'b0, r_fp[FS_LAST].adt} * {32'b0, r_fp[FS_LAST].dvx.quo};
        py = {18'b0, r_fp[FS_LAST].adt} * {32'b0, r_fp[FS_LAST].dvy.quo};
        gx = {25'b0, r_fp[FS_LAST].mvx} * {16'b0, r_fp[FS_LAST].drag};
        gy = {25'b0, r_fp[FS_LAST].mvy} * {16'b0, r_fp[FS_LAST].drag};
        n_mul.vx     = r_fp[FS_LAST].vx;
        n_mul.vy     = r_fp[FS_LAST].vy;
        n_mul.sx     = r_fp[FS_LAST].sx;
        n_mul.sy     = r_fp[FS_LAST].sy;
        n_mul.svx    = r_fp[FS_LAST].svx;
        n_mul.svy    = r_fp[FS_LAST].svy;
        n_mul.dir_nz = r_fp[FS_LAST].dir_nz;
        n_mul.ms     = r_fp[FS_LAST].ms;
        n_mul.dvx    = px[49:32];
        n_mul.dvy    = py[49:32];
        n_mul.dgx    = gx[40:24];
        n_mul.dgy    = gy[40:24];
    end

    always_comb begin
        logic signed [18:0] ex;
        logic signed [18:0] ey;
        logic signed [18:0] ax;
        logic signed [18:0] ay;
        logic signed [18:0] gx;
        logic signed [18:0] gy;
        ex = 19'(r_mul.vx);
        ey = 19'(r_mul.vy);
        ax = {1'b0, r_mul.dvx};
        ay = {1'b0, r_mul.dvy};
        gx = {2'b0, r_mul.dgx};
        gy = {2'b0, r_mul.dgy};
        n_mid.ms = r_mul.ms;
        if (r_mul.dir_nz) begin
            n_mid.vx = r_mul.sx ? ex - ax : ex + ax;
            n_mid.vy = r_mul.sy ? ey - ay : ey + ay;
        end else begin
            n_mid.vx = r_mul.svx ? -gx : gx;
            n_mid.vy = r_mul.svy ? -gy : gy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= FS_LAST; k++) begin
                r_fp[k] <= n_fp[k];
            end
            r_mul <= n_mul;
            r_mid <= n_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
            r_mv <= 1'b0;
            r_dv <= 1'b0;
        end else if (i_en) begin
            r_fv <= {r_fv[FS_LAST-1:0], i_valid};
            r_mv <= r_fv[FS_LAST];
            r_dv <= r_mv;
        end
    end

    assign o_valid = r_dv;
    assign o_mid   = r_mid;

endmodule

@@ rtl/velocity_update_drag_clamp_core.sv @@
// structure: one square root and a pair of divides (x and y) per half, each resolving one
// bit per pipeline stage
// throughput: one request per cycle; a stalled result holds the whole pipeline
// reset: synchronous, active low, clears all valid bits; data registers are not reset
module velocity_update_drag_clamp_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  vudc_pkg::t_vel_req i_req,
    output logic               o_valid,
    input  logic               i_stall,
    output vudc_pkg::t_vel_rsp o_rsp
);

    localparam int BK_LAST = vudc_pkg::SQ_N + 1 + vudc_pkg::DV_Q;

    typedef struct packed {
        logic signed [18:0] vx;
        logic signed [18:0] vy;
        logic [17:0]        mvx;
        logic [17:0]        mvy;
        logic [14:0]        ms;
        logic [35:0]        sqx;
        logic [35:0]        sqy;
        logic [29:0]        mss;
        logic [32:0]        pvx;
        logic [32:0]        pvy;
        logic               clamp;
        vudc_pkg::t_sq      sq;
        vudc_pkg::t_dv      dvx;
        vudc_pkg::t_dv      dvy;
    } t_back;

    logic               w_en;
    logic               w_mv;
    vudc_pkg::t_mid     w_mid;
    t_back              r_bk [0:BK_LAST];
    t_back              n_bk [0:BK_LAST];
    logic [BK_LAST:0]   r_bv;
    vudc_pkg::t_vel_rsp r_out;
    vudc_pkg::t_vel_rsp n_out;
    logic               r_ov;

    // whole pipeline moves unless a result is waiting and held off
    assign w_en    = !(r_ov && i_stall);
    assign o_stall = !w_en;

    vudc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_req   (i_req),
        .o_valid (w_mv),
        .o_mid   (w_mid)
    );

    always_comb begin
        logic [18:0]   ux;
        logic [18:0]   uy;
        logic [36:0]   l2;
        vudc_pkg::t_dv tx;
        vudc_pkg::t_dv ty;
        ux = w_mid.vx;
        uy = w_mid.vy;
        tx = '0;
        ty = '0;
        l2 = '0;
        n_bk[0]     = '0;
        n_bk[0].vx  = w_mid.vx;
        n_bk[0].vy  = w_mid.vy;
        n_bk[0].ms  = w_mid.ms;
        n_bk[0].mvx = ux[18] ? 18'(~ux + 19'd1) : ux[17:0];
        n_bk[0].mvy = uy[18] ? 18'(~uy + 19'd1) : uy[17:0];
        n_bk[0].sqx = {18'b0, n_bk[0].mvx} * {18'b0, n_bk[0].mvx};
        n_bk[0].sqy = {18'b0, n_bk[0].mvy} * {18'b0, n_bk[0].mvy};
        n_bk[0].pvx = {15'b0, n_bk[0].mvx} * {18'b0, w_mid.ms};
        n_bk[0].pvy = {15'b0, n_bk[0].mvy} * {18'b0, w_mid.ms};
        n_bk[0].mss = {15'b0, w_mid.ms} * {15'b0, w_mid.ms};

        for (int k = 1; k <= BK_LAST; k++) begin
            n_bk[k] = r_bk[k-1];
            if (k == 1) begin
                l2 = {1'b0, r_bk[k-1].sqx} + {1'b0, r_bk[k-1].sqy};
                n_bk[k].clamp   = l2 > {7'b0, r_bk[k-1].mss};
                n_bk[k].sq.rem  = '0;
                n_bk[k].sq.root = '0;
                n_bk[k].sq.src  = {1'b0, l2, 16'b0};
            end else if (k <= vudc_pkg::SQ_N + 1) begin
                n_bk[k].sq = vudc_pkg::sq_step(r_bk[k-1].sq);
            end else begin
                if (k == vudc_pkg::SQ_N + 2) begin
                    // numerator is (|v| * cap) << 8
                    tx.rem  = vudc_pkg::DV_W'(r_bk[k-1].pvx[32:10]);
                    tx.tail = {r_bk[k-1].pvx[9:0], 8'b0};
                    tx.quo  = '0;
                    ty.rem  = vudc_pkg::DV_W'(r_bk[k-1].pvy[32:10]);
                    ty.tail = {r_bk[k-1].pvy[9:0], 8'b0};
                    ty.quo  = '0;
                end else begin
                    tx = r_bk[k-1].dvx;
                    ty = r_bk[k-1].dvy;
                end
                n_bk[k].dvx = vudc_pkg::dv_step(tx, r_bk[k-1].sq.root);
                n_bk[k].dvy = vudc_pkg::dv_step(ty, r_bk[k-1].sq.root);
            end
        end
    end

    always_comb begin
        logic signed [19:0] qx;
        logic signed [19:0] qy;
        logic signed [19:0] fx;
        logic signed [19:0] fy;
        qx = {2'b0, r_bk[BK_LAST].dvx.quo};
        qy = {2'b0, r_bk[BK_LAST].dvy.quo};
        if (r_bk[BK_LAST].clamp) begin
            fx = r_bk[BK_LAST].vx[18] ? -qx : qx;
            fy = r_bk[BK_LAST].vy[18] ? -qy : qy;
        end else begin
            fx = 20'(r_bk[BK_LAST].vx);
            fy = 20'(r_bk[BK_LAST].vy);
        end
        if (fx > 20'sd32767) begin
            n_out.new_vel_x = 16'sh7fff;
        end else if (fx < -20'sd32768) begin
            n_out.new_vel_x = 16'sh8000;
        end else begin
            n_out.new_vel_x = fx[15:0];
        end
        if (fy > 20'sd32767) begin
            n_out.new_vel_y = 16'sh7fff;
        end else if (fy < -20'sd32768) begin
            n_out.new_vel_y = 16'sh8000;
        end else begin
            n_out.new_vel_y = fy[15:0];
        end
        n_out.was_clamped = r_bk[BK_LAST].clamp;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k <= BK_LAST; k++) begin
                r_bk[k] <= n_bk[k];
            end
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_bv <= {r_bv[BK_LAST-1:0], w_mv};
            r_ov <= r_bv[BK_LAST];
        end
    end

    assign o_valid = r_ov;
    assign o_rsp   = r_out;

endmodule

@@ rtl/vudc_checker.sv @@
module vudc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input vudc_pkg::t_vel_req i_req,
    input logic               o_valid,
    input logic               i_stall,
    input vudc_pkg::t_vel_rsp o_rsp
);

    // a held result stays put
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rsp))
        else $error("held result changed");

    // input side stalls exactly when a result is held off
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall not tied to output backpressure");

    // reset leaves no result behind
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind velocity_update_drag_clamp_core vudc_checker u_vudc_checker (.*);
